// ===== rtl/fcs_pkg.sv =====
// Shared types and constants for the scaled FIR convolution block.
package fcs_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned Y_W     = 40;
  localparam int unsigned CNT_W   = 24;
  localparam int unsigned TAPC_W  = 7;
  localparam int unsigned DT_W    = 16;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned PROD_W  = 2 * VALUE_W;

  localparam logic [TAPC_W-1:0] TAP_COUNT_RESET = 7'd64;
  localparam logic [DT_W-1:0]   DT_SCALE_RESET  = 16'd256;
  localparam logic [CNT_W-1:0]  CNT_MAX         = {CNT_W{1'b1}};

  localparam logic REG_TAP_COUNT = 1'b0;
  localparam logic REG_DT_SCALE  = 1'b1;

  localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_LOAD    = 2'd1,
    OP_RESTART = 2'd2
  } fcs_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_DRAIN,
    ST_SCALE,
    ST_DONE
  } fcs_state_t;

  typedef struct packed {
    logic [1:0]                op;
    logic [SLOT_W-1:0]         tap_index;
    logic signed [VALUE_W-1:0] value;
  } fcs_in_t;

  typedef struct packed {
    logic signed [Y_W-1:0] y;
    logic [CNT_W-1:0]      sample_index;
  } fcs_out_t;

  typedef struct packed {
    logic shift;
    logic rotate;
    logic clear;
  } fcs_cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic scale;
  } fcs_mac_ctrl_t;

endpackage

// ===== rtl/fir_convolution_scaled.sv =====
// Top level of the scaled FIR convolution: cell ring, MAC, control and registers.
//
//  channel | signals                                    | word
//  --------+--------------------------------------------+-------------------------
//  in      | in_valid, in_ready, in_data                | op, tap_index, value
//  out     | out_valid, out_ready, out_data             | y, sample_index
//  cfg     | psel, penable, pwrite, paddr, pwdata, ...  | tap_count, dt_scale
//
//  out_valid rises after a sample word is taken, once the ring has made one full turn of
//  all TAPS cells past the single MAC, followed by drain, scale and output load.
//  A sample word holds in_ready low until the output load; load and restart words do not.
//  One word is in work at a time; a result waits in the output register while the next
//  word is taken, and the output load stalls while that register is full and out_ready low.
//  Reset clears the history, the counter, the FSM and the registers to defaults.
module fir_convolution_scaled #(
  parameter int unsigned TAPS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fcs_pkg::fcs_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fcs_pkg::fcs_out_t out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import fcs_pkg::*;

  localparam int unsigned IX_W  = $clog2(TAPS);
  localparam int unsigned ACC_W = PROD_W + IX_W;
  localparam int unsigned CMP_W = (IX_W + 1 > TAPC_W) ? IX_W + 1 : TAPC_W;
  localparam int unsigned SL_W  = (IX_W > SLOT_W) ? IX_W : SLOT_W;

  fcs_state_t               state, state_next;
  logic [IX_W-1:0]          cnt, cnt_next;
  logic [TAPC_W-1:0]        tap_count;
  logic [DT_W-1:0]          dt_scale;
  logic [CNT_W-1:0]         sample_counter;
  logic [CNT_W-1:0]         index_hold;
  logic                     in_acc;
  logic                     cfg_wr;
  logic                     out_load;
  fcs_cell_ctrl_t           cell_ctrl;
  fcs_mac_ctrl_t            mac_ctrl;
  logic [TAPS-1:0]          load_en;
  logic signed [VALUE_W-1:0] coef_q   [TAPS];
  logic signed [VALUE_W-1:0] sample_q [TAPS];
  logic signed [Y_W-1:0]    y_mac;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RESET;
      dt_scale  <= DT_SCALE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TAP_COUNT: tap_count <= pwdata[TAPC_W-1:0];
        REG_DT_SCALE:  dt_scale  <= pwdata[DT_W-1:0];
        default:       tap_count <= tap_count;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TAP_COUNT: prdata = 32'(tap_count);
      REG_DT_SCALE:  prdata = 32'(dt_scale);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    cell_ctrl      = '0;
    mac_ctrl       = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          case (in_data.op)
            OP_SAMPLE: begin
              cell_ctrl.shift = 1'b1;
              mac_ctrl.clear  = 1'b1;
              cnt_next        = '0;
              state_next      = ST_ROT;
            end
            OP_RESTART: cell_ctrl.clear = 1'b1;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_ROT: begin
        cell_ctrl.rotate = 1'b1;
        mac_ctrl.take    = (CMP_W'(cnt) < CMP_W'(tap_count)) || (cnt == '0);
        cnt_next         = cnt + 1'b1;
        if (cnt == IX_W'(TAPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_SCALE;
      ST_SCALE: begin
        mac_ctrl.scale = 1'b1;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
    end else if (in_acc && in_data.op == OP_RESTART) begin
      sample_counter <= '0;
    end else if (in_acc && in_data.op == OP_SAMPLE && sample_counter != CNT_MAX) begin
      sample_counter <= sample_counter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.op == OP_SAMPLE) begin
      index_hold <= sample_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.y            <= y_mac;
      out_data.sample_index <= index_hold;
    end
  end

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    assign load_en[i] = in_acc && in_data.op == OP_LOAD &&
                        SL_W'(in_data.tap_index) == SL_W'(i);
    fcs_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (cell_ctrl),
      .load          (load_en[i]),
      .load_value    (in_data.value),
      .shift_in      ((i == 0) ? in_data.value : sample_q[(i + TAPS - 1) % TAPS]),
      .rot_coef_in   (coef_q[(i + 1) % TAPS]),
      .rot_sample_in (sample_q[(i + 1) % TAPS]),
      .coef          (coef_q[i]),
      .sample        (sample_q[i])
    );
  end

  fcs_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .coef   (coef_q[0]),
    .sample (sample_q[0]),
    .dt     (dt_scale),
    .y      (y_mac)
  );

endmodule

// ===== rtl/fcs_cell.sv =====
// One ring cell: holds one coefficient and one history sample.
module fcs_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  fcs_pkg::fcs_cell_ctrl_t             ctrl,
  input  logic                                load,
  input  logic signed [fcs_pkg::VALUE_W-1:0]  load_value,
  input  logic signed [fcs_pkg::VALUE_W-1:0]  shift_in,
  input  logic signed [fcs_pkg::VALUE_W-1:0]  rot_coef_in,
  input  logic signed [fcs_pkg::VALUE_W-1:0]  rot_sample_in,
  output logic signed [fcs_pkg::VALUE_W-1:0]  coef,
  output logic signed [fcs_pkg::VALUE_W-1:0]  sample
);
  import fcs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (ctrl.clear) begin
      sample <= '0;
    end else if (ctrl.shift) begin
      sample <= shift_in;
    end else if (ctrl.rotate) begin
      sample <= rot_sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      coef <= load_value;
    end else if (ctrl.rotate) begin
      coef <= rot_coef_in;
    end
  end

endmodule

// ===== rtl/fcs_mac.sv =====
// Multiply-accumulate, dt scaling, rounding and saturation.
module fcs_mac #(
  parameter int unsigned ACC_W = 38
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fcs_pkg::fcs_mac_ctrl_t              ctrl,
  input  logic signed [fcs_pkg::VALUE_W-1:0]  coef,
  input  logic signed [fcs_pkg::VALUE_W-1:0]  sample,
  input  logic [fcs_pkg::DT_W-1:0]            dt,
  output logic signed [fcs_pkg::Y_W-1:0]      y
);
  import fcs_pkg::*;

  localparam int unsigned SC_W = ACC_W + DT_W + 1;
  localparam int unsigned RW   = SC_W - 8;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_en;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SC_W-1:0]   scaled;
  logic signed [SC_W-1:0]   biased;
  logic signed [RW-1:0]     rnd;
  logic [RW-Y_W:0]          hi;

  always_ff @(posedge clk) begin
    prod <= coef * sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_en <= 1'b0;
    end else begin
      prod_en <= ctrl.take;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scale) begin
      scaled <= SC_W'(acc) * SC_W'($signed({1'b0, dt}));
    end
  end

  always_comb begin
    biased = scaled + SC_W'(128);
    rnd    = RW'(biased >>> 8);
    hi     = rnd[RW-1:Y_W-1];
    if (&hi || ~|hi) begin
      y = rnd[Y_W-1:0];
    end else if (rnd[RW-1]) begin
      y = Y_MIN;
    end else begin
      y = Y_MAX;
    end
  end

endmodule
